// ----- sv/mlfp_pkg.sv -----
// Package for the M-Bus long frame record parser.
// Types, codes, lookup functions and constants shared by the parser files.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlfp_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h68;
  localparam int unsigned EXT_BIT     = 7;
  localparam logic [7:0] MIN_OFFSET   = 8'd4;
  localparam logic [7:0] RESET_OFFSET = 8'd19;
  localparam logic [8:0] HDR_BYTES    = 9'd4;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_FIRST_OFFSET = '0;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_LEN_DIFF  = 3'd2,
    ST_CSUM      = 3'd3,
    ST_CUT       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_DIF  = 3'd0,
    PH_DIFE = 3'd1,
    PH_VIF  = 3'd2,
    PH_VIFE = 3'd3,
    PH_DATA = 3'd4,
    PH_CUT  = 3'd5
  } phase_t;

  // classified byte held in the queue between front and back
  typedef struct packed {
    logic [7:0] rx;
    logic       fs;
    logic       sync;
    logic [7:0] weight;
  } q_ent_t;

  typedef struct packed {
    logic [8:0]  pos;
    logic [7:0]  udl;
    logic [7:0]  csum;
    logic        dead;
    phase_t      phase;
    logic [3:0]  left;
    logic [2:0]  idx;
    logic [7:0]  dif;
    logic [7:0]  vif;
    logic [8:0]  hoff;
    logic [53:0] bcd;
    logic [63:0] raw;
  } pstate_t;

  typedef struct packed {
    logic        kind;
    logic [8:0]  offset;
    logic [7:0]  dif;
    logic [7:0]  vif;
    logic [3:0]  len;
    logic [53:0] bcd;
    logic [63:0] raw;
    status_t     status;
  } result_t;

  function automatic logic [3:0] data_len_f(input logic [2:0] code);
    logic [3:0] n;
    case (code)
      3'd0:    n = 4'd0;
      3'd1:    n = 4'd1;
      3'd2:    n = 4'd2;
      3'd3:    n = 4'd3;
      3'd4:    n = 4'd4;
      3'd5:    n = 4'd4;
      3'd6:    n = 4'd6;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [46:0] pow100_f(input logic [2:0] k);
    logic [46:0] p;
    case (k)
      3'd0:    p = 47'd1;
      3'd1:    p = 47'd100;
      3'd2:    p = 47'd10000;
      3'd3:    p = 47'd1000000;
      3'd4:    p = 47'd100000000;
      3'd5:    p = 47'd10000000000;
      3'd6:    p = 47'd1000000000000;
      default: p = 47'd100000000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mlfp_if.sv -----
// Valid/ready channel interfaces for the parser input bytes and results.
// Depends on nothing beyond the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mlfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mlfp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [8:0]  record_offset;
  logic [7:0]  dif_byte;
  logic [7:0]  vif_byte;
  logic [3:0]  data_length;
  logic [53:0] bcd_value;
  logic [63:0] raw_value;
  logic [2:0]  status;

  modport source (
    output valid, output result_kind, output record_offset, output dif_byte,
    output vif_byte, output data_length, output bcd_value, output raw_value,
    output status, input ready
  );
  modport sink (
    input valid, input result_kind, input record_offset, input dif_byte,
    input vif_byte, input data_length, input bcd_value, input raw_value,
    input status, output ready
  );
endinterface

`default_nettype wire

// ----- sv/mlfp_front.sv -----
// Front end: takes input transfers and classifies each byte for the queue.
// Depends on mlfp_pkg and mlfp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mlfp_front (
  mlfp_in_if.sink         in_ch,
  input  wire logic       q_full,
  output logic            q_push,
  output mlfp_pkg::q_ent_t q_ent
);
  import mlfp_pkg::*;

  assign in_ch.ready = ~q_full;
  assign q_push      = in_ch.valid & ~q_full;

  always_comb begin
    q_ent.rx     = in_ch.rx_byte;
    q_ent.fs     = in_ch.frame_start;
    q_ent.sync   = (in_ch.rx_byte == SYNC_BYTE);
    // BCD byte weight: ten per high nibble plus low nibble
    q_ent.weight = ({1'b0, in_ch.rx_byte[7:4], 3'b000}
                   + {3'b000, in_ch.rx_byte[7:4], 1'b0})
                   + {4'b0000, in_ch.rx_byte[3:0]};
  end

endmodule

`default_nettype wire

// ----- sv/mlfp_fifo.sv -----
// Short queue of classified bytes between front and back.
// Depends on mlfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlfp_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mlfp_pkg::q_ent_t wr_ent,
  input  wire logic             pop,
  output mlfp_pkg::q_ent_t      rd_ent,
  output logic                  full,
  output logic                  empty
);
  import mlfp_pkg::*;

  q_ent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt;
  logic [QPTR_W-1:0]   rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_ent = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? QPTR_W'((int'(wp_r) + 1) % QDEPTH) : wp_r;
    rp_nxt  = pop ? QPTR_W'((int'(rp_r) + 1) % QDEPTH) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_ent;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mlfp_back.sv -----
// Back end: frame/record parser state machine and registered result stage.
// Depends on mlfp_pkg and mlfp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mlfp_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  first_offset,
  input  wire logic        q_empty,
  input  wire mlfp_pkg::q_ent_t q_ent,
  output logic             q_pop,
  mlfp_out_if.source       out_ch
);
  import mlfp_pkg::*;

  pstate_t st_r, st_nxt;
  pstate_t st_rst;
  result_t out_r, out_nxt;
  logic    out_valid_r;
  logic    res_v;

  assign q_pop = ~q_empty & (~out_valid_r | out_ch.ready);

  // idle parser: no frame in progress
  always_comb begin
    st_rst       = '0;
    st_rst.dead  = 1'b1;
    st_rst.phase = PH_DIF;
  end

  always_comb begin
    logic [8:0]  pos;
    logic [8:0]  lim;
    logic [3:0]  n;
    logic        vdone;
    logic        do_rec;
    logic        do_st;
    status_t     st_code;
    logic [7:0]  off_c;

    pos     = '0;
    lim     = '0;
    n       = '0;
    vdone   = 1'b0;
    do_rec  = 1'b0;
    do_st   = 1'b0;
    st_code = ST_OK;
    off_c   = (first_offset < MIN_OFFSET) ? MIN_OFFSET : first_offset;
    st_nxt  = st_r;
    out_nxt = '0;
    res_v   = 1'b0;

    if (q_pop) begin
      if (q_ent.fs) begin
        st_nxt       = '0;
        st_nxt.phase = PH_DIF;
        st_nxt.hoff  = {1'b0, off_c};
      end
      if (!st_nxt.dead) begin
        pos        = st_nxt.pos;
        lim        = {1'b0, st_nxt.udl} + HDR_BYTES;
        st_nxt.pos = pos + 1'b1;
        if (pos == 9'd0) begin
          if (!q_ent.sync) begin
            do_st   = 1'b1;
            st_code = ST_BAD_START;
          end
        end else if (pos == 9'd1) begin
          st_nxt.udl = q_ent.rx;
        end else if (pos == 9'd2) begin
          if (q_ent.rx != st_nxt.udl) begin
            do_st   = 1'b1;
            st_code = ST_LEN_DIFF;
          end
        end else if (pos == 9'd3) begin
          if (!q_ent.sync) begin
            do_st   = 1'b1;
            st_code = ST_BAD_START;
          end
        end else if (pos < lim) begin
          st_nxt.csum = st_nxt.csum + q_ent.rx;
          unique case (st_nxt.phase)
            PH_DIF: begin
              if (pos == st_nxt.hoff) begin
                st_nxt.dif   = q_ent.rx;
                st_nxt.phase = q_ent.rx[EXT_BIT] ? PH_DIFE : PH_VIF;
              end
            end
            PH_DIFE: begin
              if (!q_ent.rx[EXT_BIT]) begin
                st_nxt.phase = PH_VIF;
              end
            end
            PH_VIF: begin
              st_nxt.vif = q_ent.rx;
              if (q_ent.rx[EXT_BIT]) begin
                st_nxt.phase = PH_VIFE;
              end else begin
                vdone = 1'b1;
              end
            end
            PH_VIFE: begin
              if (!q_ent.rx[EXT_BIT]) begin
                vdone = 1'b1;
              end
            end
            PH_DATA: begin
              st_nxt.bcd = st_nxt.bcd
                           + ({46'd0, q_ent.weight} * {7'd0, pow100_f(st_nxt.idx)});
              st_nxt.raw = st_nxt.raw
                           | ({56'd0, q_ent.rx} << {st_nxt.idx, 3'b000});
              st_nxt.idx = st_nxt.idx + 1'b1;
              if (st_nxt.left != 4'd0) begin
                st_nxt.left = st_nxt.left - 1'b1;
              end
              if (st_nxt.left == 4'd0) begin
                do_rec = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (vdone) begin
            n          = data_len_f(st_nxt.dif[2:0]);
            st_nxt.bcd = '0;
            st_nxt.raw = '0;
            st_nxt.idx = '0;
            if (n == 4'd0) begin
              do_rec = 1'b1;
            end else begin
              st_nxt.left  = n;
              st_nxt.phase = PH_DATA;
            end
          end
        end else if (pos == lim) begin
          st_nxt.csum = st_nxt.csum ^ q_ent.rx;
          if (st_nxt.phase != PH_DIF) begin
            st_nxt.phase = PH_CUT;
          end
        end else begin
          do_st = 1'b1;
          if (st_nxt.csum != 8'd0) begin
            st_code = ST_CSUM;
          end else if (st_nxt.phase == PH_CUT) begin
            st_code = ST_CUT;
          end else begin
            st_code = ST_OK;
          end
        end

        if (do_rec) begin
          res_v          = 1'b1;
          out_nxt.kind   = KIND_RECORD;
          out_nxt.offset = st_nxt.hoff;
          out_nxt.dif    = st_nxt.dif;
          out_nxt.vif    = st_nxt.vif;
          out_nxt.len    = data_len_f(st_nxt.dif[2:0]);
          out_nxt.bcd    = st_nxt.bcd;
          out_nxt.raw    = st_nxt.raw;
          out_nxt.status = ST_OK;
          st_nxt.hoff    = pos + 1'b1;
          st_nxt.phase   = PH_DIF;
        end
        if (do_st) begin
          res_v          = 1'b1;
          out_nxt        = '0;
          out_nxt.kind   = KIND_STATUS;
          out_nxt.status = st_code;
          st_nxt.dead    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= st_rst;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (q_pop && res_v) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_v) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = out_r.kind;
  assign out_ch.record_offset = out_r.offset;
  assign out_ch.dif_byte      = out_r.dif;
  assign out_ch.vif_byte      = out_r.vif;
  assign out_ch.data_length   = out_r.len;
  assign out_ch.bcd_value     = out_r.bcd;
  assign out_ch.raw_value     = out_r.raw;
  assign out_ch.status        = out_r.status;

endmodule

`default_nettype wire

// ----- sv/mbus_long_frame_record_parser.sv -----
// Result path: the byte transfer that causes a result passes through the byte queue
// and then the result register before the result is valid.
// Throughput: one byte per cycle while the result port is not stalled, set by the
// back end's parse step (BCD constant-table multiply and 54-bit add); a stalled
// result port fills the two-entry byte queue before the input stalls.
// Reset (rst_n low, synchronous): no frame in progress, queue and result empty,
// first record offset 19.
`timescale 1ns / 1ps
`default_nettype none

module mbus_long_frame_record_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mlfp_in_if.sink                          in_ch,
  mlfp_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [mlfp_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [mlfp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [mlfp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import mlfp_pkg::*;

  logic       q_push, q_pop, q_full, q_empty;
  q_ent_t     q_wr, q_rd;
  logic [7:0] first_offset_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_offset_r <= RESET_OFFSET;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_FIRST_OFFSET)) begin
      first_offset_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_FIRST_OFFSET)
                      ? {{(CFG_DW-8){1'b0}}, first_offset_r} : '0;

  mlfp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_ent  (q_wr)
  );

  mlfp_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_ent (q_wr),
    .pop    (q_pop),
    .rd_ent (q_rd),
    .full   (q_full),
    .empty  (q_empty)
  );

  mlfp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .first_offset (first_offset_r),
    .q_empty      (q_empty),
    .q_ent        (q_rd),
    .q_pop        (q_pop),
    .out_ch       (out_ch)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_status_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == KIND_STATUS) |->
      (out_ch.record_offset == '0 && out_ch.raw_value == '0 &&
       out_ch.bcd_value == '0 && out_ch.data_length == '0))
    else $error("status result carries record fields");

  a_record_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind == KIND_RECORD) |->
      (out_ch.status == ST_OK && out_ch.data_length <= 4'd8 &&
       out_ch.record_offset >= 9'd4))
    else $error("record result out of range");
`endif

endmodule

`default_nettype wire
